// ===== hw/rtl/mgf_pkg.sv =====
package mgf_pkg;

    // field widths
    localparam int unsigned GYRO_W   = 24;
    localparam int unsigned ACCEL_W  = 16;
    localparam int unsigned DIV_W    = 16;
    localparam int unsigned STRONG_W = 15;
    localparam int unsigned ROT_W    = 18;
    localparam int unsigned MOTION_W = 6;
    localparam int unsigned CFG_W    = 24;
    localparam int unsigned CFG_IDX_W = 3;

    // gyro difference and threshold widths (500 * 65535 fits in 25 bits)
    localparam int unsigned GDIFF_W = GYRO_W + 1;
    localparam int unsigned THR_W   = 25;
    localparam int unsigned CMP_W   = THR_W + 1;

    // rotation levels
    localparam int unsigned LVL_WEAK   = 100;
    localparam int unsigned LVL_MID    = 200;
    localparam int unsigned LVL_STRONG = 500;

    // offsets of each level group inside the rotation flags
    localparam int unsigned OFS_MID    = 0;
    localparam int unsigned OFS_WEAK   = 6;
    localparam int unsigned OFS_STRONG = 12;

    // rotation bit positions inside one level group
    localparam int unsigned ROT_Z_POS = 0;
    localparam int unsigned ROT_Z_NEG = 1;
    localparam int unsigned ROT_Y_NEG = 2;
    localparam int unsigned ROT_Y_POS = 3;
    localparam int unsigned ROT_X_POS = 4;
    localparam int unsigned ROT_X_NEG = 5;

    // motion flag positions
    localparam int unsigned MOT_UP    = 0;
    localparam int unsigned MOT_DOWN  = 1;
    localparam int unsigned MOT_FRONT = 2;
    localparam int unsigned MOT_BACK  = 3;
    localparam int unsigned MOT_RIGHT = 4;
    localparam int unsigned MOT_LEFT  = 5;

    // accelerometer decision levels
    localparam logic signed [ACCEL_W-1:0] ACC_UP_LVL    = 16'sd100;
    localparam logic signed [ACCEL_W-1:0] ACC_POS_LVL   = 16'sd200;
    localparam logic signed [ACCEL_W-1:0] ACC_NEG_LVL   = -16'sd200;
    localparam logic signed [ACCEL_W-1:0] ACC_RIGHT_LVL = -16'sd800;

    // register reset values
    localparam logic signed [ACCEL_W-1:0] ACC_OFS_X_RST = 16'sd30;
    localparam logic signed [ACCEL_W-1:0] ACC_OFS_Y_RST = 16'sd0;
    localparam logic signed [ACCEL_W-1:0] ACC_OFS_Z_RST = 16'sd1015;
    localparam logic signed [GYRO_W-1:0]  GYR_OFS_X_RST = -24'sd210;
    localparam logic signed [GYRO_W-1:0]  GYR_OFS_Y_RST = -24'sd700;
    localparam logic signed [GYRO_W-1:0]  GYR_OFS_Z_RST = 24'sd1120;
    localparam logic [DIV_W-1:0]          GYR_DIV_RST   = 16'd100;
    localparam logic [STRONG_W-1:0]       STRONG_RST    = 15'd800;

    // register index map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_OFFSET_X = 3'd0,
        REG_ACCEL_OFFSET_Y = 3'd1,
        REG_ACCEL_OFFSET_Z = 3'd2,
        REG_GYRO_OFFSET_X  = 3'd3,
        REG_GYRO_OFFSET_Y  = 3'd4,
        REG_GYRO_OFFSET_Z  = 3'd5,
        REG_GYRO_DIVISOR   = 3'd6,
        REG_STRONG_LEVEL   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [GYRO_W-1:0]  gyro_x;
        logic signed [GYRO_W-1:0]  gyro_y;
        logic signed [GYRO_W-1:0]  gyro_z;
        logic signed [ACCEL_W-1:0] accel_x;
        logic signed [ACCEL_W-1:0] accel_y;
        logic signed [ACCEL_W-1:0] accel_z;
    } t_in_item;

    typedef struct packed {
        logic [ROT_W-1:0]    rotation_flags;
        logic [MOTION_W-1:0] motion_flags;
    } t_out_item;

endpackage

// ===== hw/rtl/motion_gesture_flagger.sv =====
// channel   direction  valid        stall        payload
// ---------------------------------------------------------------
// sample    in         i_in_valid   o_in_stall   i_in_item  (t_in_item)
// flags     out        o_out_valid  i_out_stall  o_out_item (t_out_item)
// config    in         i_cfg_we     -            i_cfg_idx, i_cfg_data
//
// one transaction per cycle sustained while the output does not stall; a result
// is offered once its input has passed the input register, then the result register
// reset (synchronous, active low) empties both registers, clears held flags
// and hold counters, and loads the register defaults
// an output stall holds the result register; the input register still takes
// one more transaction, then the input stalls until the result moves on
module motion_gesture_flagger
    import mgf_pkg::*;
#(
    parameter int unsigned HOLD_SAMPLES   = 4,
    parameter int unsigned HOLD_SAMPLES_Z = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    // hold counter widths: signed, room for the doubled reload (z counter: its plain reload) and for -1
    localparam int unsigned CNT_W  = $clog2(2 * HOLD_SAMPLES + 1) + 1;
    localparam int unsigned CNTZ_W = $clog2(HOLD_SAMPLES_Z + 1) + 1;

    localparam logic signed [CNT_W-1:0]  RELOAD      = CNT_W'(HOLD_SAMPLES);
    localparam logic signed [CNT_W-1:0]  RELOAD_LONG = CNT_W'(2 * HOLD_SAMPLES);
    localparam logic signed [CNTZ_W-1:0] RELOAD_Z    = CNTZ_W'(HOLD_SAMPLES_Z);

    // configuration registers
    logic signed [ACCEL_W-1:0] r_acc_ofs_x, r_acc_ofs_y, r_acc_ofs_z;
    logic signed [GYRO_W-1:0]  r_gyr_ofs_x, r_gyr_ofs_y, r_gyr_ofs_z;
    logic [DIV_W-1:0]          r_gyr_div;
    logic [STRONG_W-1:0]       r_strong;

    // thresholds: level times gyro scale
    logic [THR_W-1:0] w_thr_weak, w_thr_mid, w_thr_strong;

    // pipeline registers
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    // gesture state
    logic [MOTION_W-1:0]     r_held, n_held;
    logic signed [CNT_W-1:0] r_cnt_x, n_cnt_x, r_cnt_y, n_cnt_y;
    logic signed [CNTZ_W-1:0] r_cnt_z, n_cnt_z;

    logic w_in_acc, w_adv, w_out_acc;

    // datapath signals
    logic signed [GDIFF_W-1:0] w_gx, w_gy, w_gz;
    logic signed [ACCEL_W-1:0] w_ax, w_ay, w_az;
    logic [ROT_W-1:0]          w_rot;
    logic                      w_zrot;
    logic [ACCEL_W:0]          w_abs_x, w_abs_y;

    // handshake
    assign w_out_acc   = r_out_valid && !i_out_stall;
    assign w_adv       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_adv;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // one direction pair at one level: d > t, or d < -t
    function automatic logic [1:0] lvl_flags(
        input logic signed [GDIFF_W-1:0] d,
        input logic [THR_W-1:0]          t
    );
        logic signed [CMP_W-1:0] ds;
        logic signed [CMP_W-1:0] ts;
        begin
            ds = CMP_W'(d);
            ts = $signed({1'b0, t});
            lvl_flags = {ds < -ts, ds > ts};
        end
    endfunction

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_ofs_x <= ACC_OFS_X_RST;
            r_acc_ofs_y <= ACC_OFS_Y_RST;
            r_acc_ofs_z <= ACC_OFS_Z_RST;
            r_gyr_ofs_x <= GYR_OFS_X_RST;
            r_gyr_ofs_y <= GYR_OFS_Y_RST;
            r_gyr_ofs_z <= GYR_OFS_Z_RST;
            r_gyr_div   <= GYR_DIV_RST;
            r_strong    <= STRONG_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_ACCEL_OFFSET_X: r_acc_ofs_x <= i_cfg_data[ACCEL_W-1:0];
                REG_ACCEL_OFFSET_Y: r_acc_ofs_y <= i_cfg_data[ACCEL_W-1:0];
                REG_ACCEL_OFFSET_Z: r_acc_ofs_z <= i_cfg_data[ACCEL_W-1:0];
                REG_GYRO_OFFSET_X:  r_gyr_ofs_x <= i_cfg_data[GYRO_W-1:0];
                REG_GYRO_OFFSET_Y:  r_gyr_ofs_y <= i_cfg_data[GYRO_W-1:0];
                REG_GYRO_OFFSET_Z:  r_gyr_ofs_z <= i_cfg_data[GYRO_W-1:0];
                REG_GYRO_DIVISOR:   r_gyr_div   <= i_cfg_data[DIV_W-1:0];
                REG_STRONG_LEVEL:   r_strong    <= i_cfg_data[STRONG_W-1:0];
                default: ;
            endcase
        end
    end

    // constant multiplies, shift and add only
    assign w_thr_weak   = THR_W'(r_gyr_div * LVL_WEAK);
    assign w_thr_mid    = THR_W'(r_gyr_div * LVL_MID);
    assign w_thr_strong = THR_W'(r_gyr_div * LVL_STRONG);

    // offset removal: gyro exact, accelerometer wraps to 16 bits
    always_comb begin
        w_gx = GDIFF_W'(r_in.gyro_x) - GDIFF_W'(r_gyr_ofs_x);
        w_gy = GDIFF_W'(r_in.gyro_y) - GDIFF_W'(r_gyr_ofs_y);
        w_gz = GDIFF_W'(r_in.gyro_z) - GDIFF_W'(r_gyr_ofs_z);
        w_ax = r_in.accel_x - r_acc_ofs_x;
        w_ay = r_in.accel_y - r_acc_ofs_y;
        w_az = r_in.accel_z - r_acc_ofs_z;
        // magnitude in 17 bits so that -32768 reads as 32768
        w_abs_x = w_ax[ACCEL_W-1] ? (ACCEL_W+1)'(-(ACCEL_W+1)'(w_ax))
                                  : (ACCEL_W+1)'(w_ax);
        w_abs_y = w_ay[ACCEL_W-1] ? (ACCEL_W+1)'(-(ACCEL_W+1)'(w_ay))
                                  : (ACCEL_W+1)'(w_ay);
    end

    // rotation flags, three levels per axis and direction
    always_comb begin
        logic [1:0] f;
        w_rot = '0;
        f = lvl_flags(w_gz, w_thr_mid);
        {w_rot[OFS_MID+ROT_Z_NEG], w_rot[OFS_MID+ROT_Z_POS]} = f;
        f = lvl_flags(w_gz, w_thr_weak);
        {w_rot[OFS_WEAK+ROT_Z_NEG], w_rot[OFS_WEAK+ROT_Z_POS]} = f;
        f = lvl_flags(w_gz, w_thr_strong);
        {w_rot[OFS_STRONG+ROT_Z_NEG], w_rot[OFS_STRONG+ROT_Z_POS]} = f;
        f = lvl_flags(w_gy, w_thr_mid);
        {w_rot[OFS_MID+ROT_Y_NEG], w_rot[OFS_MID+ROT_Y_POS]} = f;
        f = lvl_flags(w_gy, w_thr_weak);
        {w_rot[OFS_WEAK+ROT_Y_NEG], w_rot[OFS_WEAK+ROT_Y_POS]} = f;
        f = lvl_flags(w_gy, w_thr_strong);
        {w_rot[OFS_STRONG+ROT_Y_NEG], w_rot[OFS_STRONG+ROT_Y_POS]} = f;
        f = lvl_flags(w_gx, w_thr_mid);
        {w_rot[OFS_MID+ROT_X_NEG], w_rot[OFS_MID+ROT_X_POS]} = f;
        f = lvl_flags(w_gx, w_thr_weak);
        {w_rot[OFS_WEAK+ROT_X_NEG], w_rot[OFS_WEAK+ROT_X_POS]} = f;
        f = lvl_flags(w_gx, w_thr_strong);
        {w_rot[OFS_STRONG+ROT_X_NEG], w_rot[OFS_STRONG+ROT_X_POS]} = f;
        // yaw at mid level gates the x and y axis decisions
        w_zrot = w_rot[OFS_MID+ROT_Z_POS] || w_rot[OFS_MID+ROT_Z_NEG];
    end

    // per-axis hold logic: re-evaluate when the hold expired (counter
    // negative) or the axis holds no flag, else count down
    always_comb begin
        n_held  = r_held;
        n_cnt_x = r_cnt_x;
        n_cnt_y = r_cnt_y;
        n_cnt_z = r_cnt_z;

        // z axis: up / down, gated by the x roll flags
        if (r_cnt_z[CNTZ_W-1] || !(r_held[MOT_UP] || r_held[MOT_DOWN])) begin
            if (w_az > ACC_UP_LVL && w_rot[OFS_MID+ROT_X_POS]) begin
                n_held[MOT_UP] = 1'b1;
            end else if (w_az < ACC_NEG_LVL && w_rot[OFS_MID+ROT_X_NEG]) begin
                n_held[MOT_DOWN] = 1'b1;
            end else begin
                n_held[MOT_UP]   = 1'b0;
                n_held[MOT_DOWN] = 1'b0;
            end
            n_cnt_z = RELOAD_Z;
        end else begin
            n_cnt_z = r_cnt_z - CNTZ_W'(1);
        end

        // y axis: back / front
        if (r_cnt_y[CNT_W-1] || !(r_held[MOT_FRONT] || r_held[MOT_BACK])) begin
            if (w_ay > ACC_POS_LVL && w_zrot) begin
                n_held[MOT_BACK] = 1'b1;
            end else if (w_ay < ACC_NEG_LVL && w_zrot) begin
                n_held[MOT_FRONT] = 1'b1;
            end else begin
                n_held[MOT_FRONT] = 1'b0;
                n_held[MOT_BACK]  = 1'b0;
            end
            n_cnt_y = (w_abs_y > (ACCEL_W+1)'(r_strong)) ? RELOAD_LONG : RELOAD;
        end else begin
            n_cnt_y = r_cnt_y - CNT_W'(1);
        end

        // x axis: left / right, right needs a larger swing
        if (r_cnt_x[CNT_W-1] || !(r_held[MOT_RIGHT] || r_held[MOT_LEFT])) begin
            if (w_ax > ACC_POS_LVL && w_zrot) begin
                n_held[MOT_LEFT] = 1'b1;
            end else if (w_ax < ACC_RIGHT_LVL && w_zrot) begin
                n_held[MOT_RIGHT] = 1'b1;
            end else begin
                n_held[MOT_RIGHT] = 1'b0;
                n_held[MOT_LEFT]  = 1'b0;
            end
            n_cnt_x = (w_abs_x > (ACCEL_W+1)'(r_strong)) ? RELOAD_LONG : RELOAD;
        end else begin
            n_cnt_x = r_cnt_x - CNT_W'(1);
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_item;
        end
    end

    // state advances once per transaction leaving the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_cnt_x <= '0;
            r_cnt_y <= '0;
            r_cnt_z <= '0;
        end else if (w_adv) begin
            r_held  <= n_held;
            r_cnt_x <= n_cnt_x;
            r_cnt_y <= n_cnt_y;
            r_cnt_z <= n_cnt_z;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.rotation_flags <= w_rot;
            r_out.motion_flags   <= n_held;
        end
    end

`ifndef SYNTHESIS
    // an empty input register never pushes back
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("input stalled with empty input register");

    // a transaction that leaves the input register is offered next cycle
    a_adv_offers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("advanced transaction not offered");

    // held flags change only when a transaction is processed
    a_held_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_held))
        else $error("held flags changed without a transaction");

    // hold counters stay between expired and the longest reload
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_x >= -CNT_W'(1)) && (r_cnt_x <= RELOAD_LONG) &&
        (r_cnt_y >= -CNT_W'(1)) && (r_cnt_y <= RELOAD_LONG) &&
        (r_cnt_z >= -CNTZ_W'(1)) && (r_cnt_z <= RELOAD_Z))
        else $error("hold counter out of range");
`endif

endmodule
